[sv/klifd_pkg.sv]
`timescale 1ns / 1ps
// Package for the keyed list core: opcodes, status codes, controller states,
// default parameter values and the cell control struct. No dependencies.
package klifd_pkg;

  // Default sizes of the list
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 16;

  // Field widths of the stream payloads
  localparam int OP_W     = 2;
  localparam int FKEY_W   = 16;
  localparam int STATUS_W = 2;
  localparam int TAG_W    = 6;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 48;

  // Tag index is the key modulo 45, by reciprocal multiplication
  localparam int TAG_MOD   = 45;
  localparam int TAG_SHIFT = 21;
  localparam logic [15:0] TAG_RECIP = 16'd46604;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_NOT_FOUND = 2'd0,
    STS_DONE      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic capture;   // register the compare results
    logic load_ins;  // shift the row down by one, head takes the new key
    logic load_del;  // close the gap left by the matching cell
  } cell_ctrl_t;

endpackage

[sv/klifd_cell.sv]
`timescale 1ns / 1ps
// One cell of the list row: holds one key, compares it against the search
// key and shifts to or from its neighbours. Depends on klifd_pkg.
module klifd_cell #(
  parameter int KEY_BITS = klifd_pkg::KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  klifd_pkg::cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic                  occ,
  input  logic                  occ_below,
  input  logic [KEY_BITS-1:0]   key_above,
  input  logic [KEY_BITS-1:0]   key_below,
  input  logic                  hit_above,
  output logic [KEY_BITS-1:0]   key,
  output logic                  hit,
  output logic                  hit_chain,
  output logic                  has_next,
  output logic [KEY_BITS-1:0]   next_key
);

  logic                hit_nxt;
  logic [KEY_BITS-1:0] nkey;

  // Compare stage: remember whether this cell matched and its follower
  always_ff @(posedge clk) begin
    if (rst) begin
      hit     <= 1'b0;
      hit_nxt <= 1'b0;
    end else if (ctrl.capture) begin
      hit     <= occ && (key == cmp_key);
      hit_nxt <= occ && (key == cmp_key) && occ_below;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      nkey <= key_below;
    end
  end

  // Key storage: shift down on insert, shift up below a deleted entry
  always_ff @(posedge clk) begin
    if (ctrl.load_ins) begin
      key <= key_above;
    end else if (ctrl.load_del && (hit_above || hit)) begin
      key <= key_below;
    end
  end

  // Prefix of matches handed to the next cell down the row
  assign hit_chain = hit_above | hit;

  // Contribution to the result, zero unless this cell matched
  assign has_next = hit_nxt;
  assign next_key = hit_nxt ? nkey : '0;

endmodule

[sv/klifd_mod45.sv]
`timescale 1ns / 1ps
// Tag index unit: the key modulo 45 by a reciprocal multiply, registered,
// and a subtract that forms the remainder. Depends on klifd_pkg.
module klifd_mod45 (
  input  logic                          clk,
  input  logic                          capture,
  input  logic [klifd_pkg::FKEY_W-1:0]  x,
  output logic [klifd_pkg::TAG_W-1:0]   tag
);

  logic [klifd_pkg::FKEY_W-1:0]   x_r;
  logic [2*klifd_pkg::FKEY_W-1:0] prod;
  logic [10:0]                    quot;
  logic [klifd_pkg::FKEY_W-1:0]   back;
  logic [klifd_pkg::FKEY_W-1:0]   rem;

  // Multiply by the scaled reciprocal and register the product
  always_ff @(posedge clk) begin
    if (capture) begin
      x_r  <= x;
      prod <= x * klifd_pkg::TAG_RECIP;
    end
  end

  // Quotient is exact for all 16-bit values, so the remainder needs no fix-up
  always_comb begin
    quot = prod[2*klifd_pkg::FKEY_W-1:klifd_pkg::TAG_SHIFT];
    back = klifd_pkg::FKEY_W'(quot * klifd_pkg::FKEY_W'(klifd_pkg::TAG_MOD));
    rem  = x_r - back;
    tag  = rem[klifd_pkg::TAG_W-1:0];
  end

endmodule

[sv/keyed_list_insert_find_delete_core.sv]
`timescale 1ns / 1ps
// Top level of the keyed list core: controller, row of key cells and tag unit.
// Depends on klifd_pkg, klifd_cell and klifd_mod45.

// A bounded list of keys, newest first, held in a row of CAPACITY cells. Each
// transaction on the input stream is an insert, a search or a delete, and
// gives exactly one result transaction. An item is captured in the idle
// state; in the compare state every cell compares its key in parallel and
// registers the outcome; in the update state the row shifts and the result
// is written to the output register. A new item is taken only after that
// update, even while a result still waits on the output; the block holds the
// update back only when a second result would overwrite one not yet taken.
// Keys are given out from a counter starting at 1; once it wraps, or the row
// is full, inserts report full.
module keyed_list_insert_find_delete_core #(
  parameter int CAPACITY = klifd_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = klifd_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata, from bit 0: op[1:0], key[17:2], zero fill [23:18]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [klifd_pkg::S_DATA_W-1:0] s_tdata,
  // m_tdata, from bit 0: status[1:0], entry_key[17:2], tag_index[23:18],
  // has_next[24], next_key[40:25], zero fill [47:41]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [klifd_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int FK    = klifd_pkg::FKEY_W;

  klifd_pkg::state_t     state, state_next;
  klifd_pkg::cell_ctrl_t ctrl;

  logic [klifd_pkg::OP_W-1:0] op;
  logic [KEY_BITS-1:0]        key_r;
  logic [KEY_BITS-1:0]        key_in;
  logic [KEY_BITS-1:0]        key_counter;
  logic [CNT_W-1:0]           entry_count;
  logic [FK-1:0]              key_r16;
  logic [FK-1:0]              counter16;
  logic [FK-1:0]              tag_x;
  logic [klifd_pkg::TAG_W-1:0] tag;

  logic [CAPACITY-1:0]  occ;
  logic [KEY_BITS-1:0]  keys    [CAPACITY];
  logic [KEY_BITS-1:0]  nkeys   [CAPACITY];
  logic [CAPACITY-1:0]  hit_vec;
  logic [CAPACITY-1:0]  nxt_vec;
  logic [CAPACITY:0]    chain;

  logic                 found;
  logic                 has_next_any;
  logic [KEY_BITS-1:0]  next_or;
  logic                 full;
  logic                 commit;

  logic [klifd_pkg::STATUS_W-1:0] status;
  logic [FK-1:0]                  entry_key;
  logic [klifd_pkg::TAG_W-1:0]    tag_index;
  logic                           has_next;
  logic [FK-1:0]                  next_key;

  // Width conversions between the 16-bit fields and the stored key width
  generate
    if (KEY_BITS >= FK) begin : g_wide
      assign key_in    = KEY_BITS'(s_tdata[17:2]);
      assign key_r16   = key_r[FK-1:0];
      assign counter16 = key_counter[FK-1:0];
    end else begin : g_narrow
      assign key_in    = s_tdata[KEY_BITS+1:2];
      assign key_r16   = FK'(key_r);
      assign counter16 = FK'(key_counter);
    end
  endgenerate

  // Input capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= s_tdata[1:0];
      key_r <= key_in;
    end
  end

  // Occupancy of each cell follows from the entry count
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_occ
      assign occ[i] = entry_count > CNT_W'(i);
    end
  endgenerate

  // Row of cells
  assign chain[0] = 1'b0;
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0] above;
      logic [KEY_BITS-1:0] below;
      logic                occ_below;
      if (i == 0) begin : g_head
        assign above = key_counter;
      end else begin : g_body
        assign above = keys[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign below     = '0;
        assign occ_below = 1'b0;
      end else begin : g_mid
        assign below     = keys[i+1];
        assign occ_below = occ[i+1];
      end
      klifd_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .cmp_key   (key_r),
        .occ       (occ[i]),
        .occ_below (occ_below),
        .key_above (above),
        .key_below (below),
        .hit_above (chain[i]),
        .key       (keys[i]),
        .hit       (hit_vec[i]),
        .hit_chain (chain[i+1]),
        .has_next  (nxt_vec[i]),
        .next_key  (nkeys[i])
      );
    end
  endgenerate

  // Merge the cell results; at most one cell matches
  always_comb begin
    next_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      next_or = next_or | nkeys[i];
    end
    found        = |hit_vec;
    has_next_any = |nxt_vec;
  end

  // Tag index unit, fed in the compare cycle
  assign tag_x = (op == klifd_pkg::OP_INSERT) ? counter16 : key_r16;

  klifd_mod45 u_mod45 (
    .clk     (clk),
    .capture (ctrl.capture),
    .x       (tag_x),
    .tag     (tag)
  );

  assign full   = (entry_count >= CNT_W'(CAPACITY)) || (key_counter == '0);
  assign commit = (state == klifd_pkg::S_UPD) && (!m_tvalid || m_tready);

  // Controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= klifd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      klifd_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = klifd_pkg::S_CMP;
        end
      end
      klifd_pkg::S_CMP: begin
        state_next = klifd_pkg::S_UPD;
      end
      klifd_pkg::S_UPD: begin
        if (!m_tvalid || m_tready) begin
          state_next = klifd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = klifd_pkg::S_IDLE;
      end
    endcase
  end

  // Controller outputs and the result of the operation
  always_comb begin
    s_tready      = 1'b0;
    ctrl.capture  = 1'b0;
    ctrl.load_ins = 1'b0;
    ctrl.load_del = 1'b0;
    case (state)
      klifd_pkg::S_IDLE: begin
        // No transaction is taken while reset is held.
        s_tready = !rst;
      end
      klifd_pkg::S_CMP: begin
        ctrl.capture = 1'b1;
      end
      klifd_pkg::S_UPD: begin
        ctrl.load_ins = commit && (op == klifd_pkg::OP_INSERT) && !full;
        ctrl.load_del = commit && (op == klifd_pkg::OP_DELETE) && found;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase

    status    = klifd_pkg::STS_NOT_FOUND;
    entry_key = '0;
    tag_index = '0;
    has_next  = 1'b0;
    next_key  = '0;
    case (op)
      klifd_pkg::OP_INSERT: begin
        if (full) begin
          status = klifd_pkg::STS_FULL;
        end else begin
          status    = klifd_pkg::STS_DONE;
          entry_key = counter16;
          tag_index = tag;
          has_next  = occ[0];
          if (occ[0]) begin
            next_key = (KEY_BITS >= FK) ? keys[0][FK-1:0] : FK'(keys[0]);
          end
        end
      end
      klifd_pkg::OP_SEARCH: begin
        if (found) begin
          status    = klifd_pkg::STS_DONE;
          entry_key = key_r16;
          tag_index = tag;
          has_next  = has_next_any;
          next_key  = (KEY_BITS >= FK) ? next_or[FK-1:0] : FK'(next_or);
        end
      end
      klifd_pkg::OP_DELETE: begin
        if (entry_count == '0) begin
          status = klifd_pkg::STS_EMPTY;
        end else if (found) begin
          status = klifd_pkg::STS_DONE;
        end
      end
      default: begin
        status = klifd_pkg::STS_NOT_FOUND;
      end
    endcase
  end

  // List bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      key_counter <= KEY_BITS'(1);
    end else if (ctrl.load_ins) begin
      entry_count <= entry_count + CNT_W'(1);
      key_counter <= key_counter + KEY_BITS'(1);
    end else if (ctrl.load_del) begin
      entry_count <= entry_count - CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {7'd0, next_key, has_next, tag_index, entry_key, status};
    end
  end

`ifndef SYNTHESIS
  // Entry count never goes beyond the row
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // Keys are unique, so no more than one cell can match
  assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell matched");

  // An accepted insert grows the list by exactly one entry
  assert property (@(posedge clk) disable iff (rst)
    ctrl.load_ins |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("insert did not grow the list");

  // A result is produced only from the update cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == klifd_pkg::S_UPD)
    else $error("result raised outside the update cycle");
`endif

endmodule

[bench/tb_keyed_list_insert_find_delete_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the keyed list core: directed list cases and
// random phases under varying back-pressure. Depends on klifd_pkg.

module tb_keyed_list_insert_find_delete_core;

  localparam int CAPACITY = klifd_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASE_ITEMS = 475;
  localparam logic [klifd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // One result transaction, split into its fields
  typedef struct packed {
    klifd_pkg::status_t status;
    logic [15:0]        entry_key;
    logic [5:0]         tag_index;
    logic               has_next;
    logic [15:0]        next_key;
  } list_result_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  // s_tdata, from bit 0: op[1:0], key[17:2], zero fill [23:18]
  logic [klifd_pkg::S_DATA_W-1:0] s_tdata;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // m_tdata, from bit 0: status[1:0], entry_key[17:2], tag_index[23:18],
  // has_next[24], next_key[40:25], zero fill [47:41]
  logic [klifd_pkg::M_DATA_W-1:0] m_tdata;

  // Shadow copy of the list contents, head first
  logic [15:0]  list_keys [CAPACITY];
  int           entry_cnt = 0;
  logic [15:0]  key_ctr = 16'd1;

  list_result_t expected_results [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  keyed_list_insert_find_delete_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one operation to the shadow list and returns the result it gives.
  function automatic list_result_t apply_list_op(input logic [klifd_pkg::OP_W-1:0] op,
                                                 input logic [15:0] key);
    list_result_t r;
    int pos;
    int i;
    r = '0;
    pos = -1;
    for (i = 0; i < entry_cnt; i++) begin
      if (pos < 0 && list_keys[i] == key) pos = i;
    end
    case (op)
      klifd_pkg::OP_INSERT: begin
        if (entry_cnt >= CAPACITY || key_ctr == 16'd0) begin
          r.status = klifd_pkg::STS_FULL;
        end else begin
          if (entry_cnt > 0) begin
            r.has_next = 1'b1;
            r.next_key = list_keys[0];
          end
          for (i = entry_cnt; i > 0; i--) list_keys[i] = list_keys[i-1];
          list_keys[0] = key_ctr;
          entry_cnt++;
          r.status = klifd_pkg::STS_DONE;
          r.entry_key = key_ctr;
          r.tag_index = 6'(int'(key_ctr) % klifd_pkg::TAG_MOD);
          key_ctr = key_ctr + 16'd1;
        end
      end
      klifd_pkg::OP_SEARCH: begin
        if (pos >= 0) begin
          r.status = klifd_pkg::STS_DONE;
          r.entry_key = key;
          r.tag_index = 6'(int'(key) % klifd_pkg::TAG_MOD);
          if (pos + 1 < entry_cnt) begin
            r.has_next = 1'b1;
            r.next_key = list_keys[pos+1];
          end
        end
      end
      klifd_pkg::OP_DELETE: begin
        if (entry_cnt == 0) begin
          r.status = klifd_pkg::STS_EMPTY;
        end else if (pos >= 0) begin
          for (i = pos; i + 1 < entry_cnt; i++) list_keys[i] = list_keys[i+1];
          entry_cnt--;
          r.status = klifd_pkg::STS_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one command, with a random gap first, and records its expected result.
  // Entered and left at a falling edge.
  task automatic send_list_op(input logic [klifd_pkg::OP_W-1:0] op, input logic [15:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(klifd_pkg::S_DATA_W - 18){1'b0}}, key, op};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(apply_list_op(op, key));
    @(negedge clk);
  endtask

  // Mostly keys held in the list, some near the counter, some at the extremes.
  function automatic logic [15:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && entry_cnt > 0) return list_keys[$urandom_range(0, entry_cnt - 1)];
    if (r < 75) return key_ctr - 16'($urandom_range(0, 20));
    if (r < 80) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // Operations on an empty list and the unused opcode.
  task automatic test_empty_list();
    send_list_op(klifd_pkg::OP_DELETE, 16'd5);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd1);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd0);
    send_list_op(OP_UNUSED, 16'hFFFF);
    send_list_op(klifd_pkg::OP_DELETE, 16'd0);
  endtask

  // Insert, search at head, middle and tail, and deletes in the middle, at the head and of the last entry.
  task automatic test_basic_ops();
    send_list_op(klifd_pkg::OP_INSERT, 16'hFFFF);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd1);
    send_list_op(klifd_pkg::OP_INSERT, 16'h0000);
    send_list_op(klifd_pkg::OP_INSERT, 16'hA5A5);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd2);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd1);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd3);
    send_list_op(klifd_pkg::OP_DELETE, 16'd7);
    send_list_op(klifd_pkg::OP_DELETE, 16'd0);
    send_list_op(klifd_pkg::OP_SEARCH, 16'hFFFF);
    send_list_op(OP_UNUSED, 16'd2);
    send_list_op(klifd_pkg::OP_DELETE, 16'd2);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd3);
    send_list_op(klifd_pkg::OP_DELETE, 16'd3);
    send_list_op(klifd_pkg::OP_DELETE, 16'd1);
    send_list_op(klifd_pkg::OP_SEARCH, 16'd1);
  endtask

  // Fill the list, check that further inserts are refused, then empty it.
  task automatic test_full_list();
    while (entry_cnt < CAPACITY) send_list_op(klifd_pkg::OP_INSERT, 16'($urandom));
    send_list_op(klifd_pkg::OP_INSERT, 16'hFFFF);
    send_list_op(klifd_pkg::OP_INSERT, 16'h0000);
    send_list_op(klifd_pkg::OP_SEARCH, list_keys[CAPACITY-1]);
    send_list_op(klifd_pkg::OP_SEARCH, list_keys[0]);
    while (entry_cnt > 0) begin
      send_list_op(klifd_pkg::OP_DELETE, list_keys[$urandom_range(0, entry_cnt - 1)]);
    end
    send_list_op(klifd_pkg::OP_DELETE, 16'd1);
  endtask

  // Random commands; the insert share swings so the list fills and drains.
  task automatic run_random_phase(input int n_items, input int send_pct,
                                  input int stall_pct);
    int i;
    int pick;
    bit fill_mode;
    logic [klifd_pkg::OP_W-1:0] op;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    fill_mode = 1'b1;
    for (i = 0; i < n_items; i++) begin
      if (i % 48 == 0) fill_mode = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < (fill_mode ? 55 : 18)) op = klifd_pkg::OP_INSERT;
      else if (pick < (fill_mode ? 75 : 70)) op = klifd_pkg::OP_DELETE;
      else op = klifd_pkg::OP_SEARCH;
      send_list_op(op, pick_key());
    end
  endtask

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input list_result_t want,
                                 input list_result_t got);
    if (mismatch_count < 10) begin
      $display("mismatch (%s): expected status=%0d key=%0d tag=%0d has_next=%0d next=%0d",
               what, want.status, want.entry_key, want.tag_index, want.has_next,
               want.next_key);
      $display("  actual: status=%0d key=%0d tag=%0d has_next=%0d next=%0d",
               got.status, got.entry_key, got.tag_index, got.has_next, got.next_key);
    end
    mismatch_count++;
  endtask

  // Compare every result transaction with the oldest expected result.
  always @(posedge clk) begin : check_results
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status    = klifd_pkg::status_t'(m_tdata[1:0]);
      got.entry_key = m_tdata[17:2];
      got.tag_index = m_tdata[23:18];
      got.has_next  = m_tdata[24];
      got.next_key  = m_tdata[40:25];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.entry_key !== want.entry_key ||
            got.tag_index !== want.tag_index || got.has_next !== want.has_next ||
            got.next_key !== want.next_key) begin
          report_mismatch("field", want, got);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    run_random_phase(RANDOM_PHASE_ITEMS, 0, 0);
    run_random_phase(RANDOM_PHASE_ITEMS, 75, 0);
    run_random_phase(RANDOM_PHASE_ITEMS, 0, 75);
    run_random_phase(RANDOM_PHASE_ITEMS, 13, 13);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[keyed_list_insert_find_delete_core.f]
sv/klifd_pkg.sv
sv/klifd_cell.sv
sv/klifd_mod45.sv
sv/keyed_list_insert_find_delete_core.sv
bench/tb_keyed_list_insert_find_delete_core.sv
